// ===== src/pse_pkg.sv =====
// pse_pkg: shared types, constants and decode helpers of the postfix stack evaluator
// no dependencies; used by pse_stack, pse_alu and postfix_stack_evaluator
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_TIMES = 8'd42;
  localparam logic [7:0] CH_DIV   = 8'd47;
  localparam logic [7:0] CH_POW   = 8'd94;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       start_new;
  } sym_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [4:0]         stack_depth;
    logic [1:0]         status;
  } res_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_PMUL,
    A_PSQ
  } alu_state_t;

  typedef struct packed {
    logic                   start;
    alu_op_t                op;
    logic [VALUE_WIDTH-1:0] left;
    logic [VALUE_WIDTH-1:0] right;
  } alu_req_t;

  typedef struct packed {
    logic                   done;
    logic                   fault;
    logic [VALUE_WIDTH-1:0] result;
  } alu_rsp_t;

  function automatic logic is_operator(input logic [7:0] sym);
    return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_TIMES) ||
           (sym == CH_DIV) || (sym == CH_POW);
  endfunction

  function automatic alu_op_t sym_to_op(input logic [7:0] sym);
    alu_op_t op;
    op = OP_ADD;
    if (sym == CH_MINUS) op = OP_SUB;
    if (sym == CH_TIMES) op = OP_MUL;
    if (sym == CH_DIV)   op = OP_DIV;
    if (sym == CH_POW)   op = OP_POW;
    return op;
  endfunction

endpackage

// ===== src/postfix_stack_evaluator.sv =====
// postfix_stack_evaluator: top level, request sequencer and result register
// depends on pse_pkg, pse_stack and pse_alu
//
//   channel  direction  handshake                payload
//   sym      in         sym_valid / sym_ready    sym_t: symbol, start_new
//   res      out        res_valid / res_ready    res_t: top_value, stack_depth, status
//
// a digit or other push request passes through accept and result
// +, - and * pass through accept, stack read with alu start, write back, result
// / waits in calc for the restoring divide and sign fix in pse_alu
// ^ with a positive exponent waits in calc for two multiplier passes per exponent bit in pse_alu
// reset clears the stack pointer, sequencer and result valid; stack contents stay as is
// a result waiting on res_ready holds only the next finished result, not acceptance
module postfix_stack_evaluator (
  input  logic          clk,
  input  logic          rst,
  input  logic          sym_valid,
  output logic          sym_ready,
  input  pse_pkg::sym_t sym,
  output logic          res_valid,
  input  logic          res_ready,
  output pse_pkg::res_t res
);
  import pse_pkg::*;

  localparam int W = VALUE_WIDTH;

  seq_state_t   state, state_next;
  logic [PTR_W-1:0] sp, sp_next;
  logic [W-1:0] top, top_next;
  logic [W-1:0] right_v, right_v_next;
  alu_op_t      op, op_next;
  logic         under, under_next;
  logic [1:0]   status_r, status_r_next;
  res_t         res_next;
  logic         res_valid_next;

  // stack port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [W-1:0]     wr_data, rd_data;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // request decode
  logic [PTR_W-1:0] sp_eff;
  logic             sym_is_op;
  logic [W-1:0]     push_val;
  logic             sp_ge2;
  logic [PTR_W-1:0] base_sp;

  assign sp_eff    = sym.start_new ? '0 : sp;
  assign sym_is_op = is_operator(sym.symbol);
  assign push_val  = W'(sym.symbol) - W'(CH_ZERO);
  assign sp_ge2    = (sp >= PTR_W'(2));
  // depth left after two pops
  assign base_sp   = sp_ge2 ? (sp - PTR_W'(2)) : '0;

  pse_stack u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sp        <= sp_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    right_v  <= right_v_next;
    op       <= op_next;
    under    <= under_next;
    status_r <= status_r_next;
    res      <= res_next;
  end

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    top_next       = top;
    right_v_next   = right_v;
    op_next        = op;
    under_next     = under;
    status_r_next  = status_r;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;

    sym_ready = (state == S_IDLE);

    wr_en   = 1'b0;
    wr_addr = sp_eff[IDX_W-1:0];
    wr_data = push_val;
    // left operand sits just below the top entry, two below the stack pointer
    rd_addr = IDX_W'(sp_eff - PTR_W'(2));

    alu_req.start = 1'b0;
    alu_req.op    = op;
    alu_req.left  = sp_ge2 ? rd_data : W'(CH_ZERO);
    alu_req.right = right_v;

    unique case (state)
      S_IDLE: begin
        if (sym_valid) begin
          if (sym_is_op) begin
            // right operand is the cached top; a missing one reads as '0'
            sp_next      = sp_eff;
            op_next      = sym_to_op(sym.symbol);
            right_v_next = (sp_eff != '0) ? top : W'(CH_ZERO);
            under_next   = (sp_eff < PTR_W'(2));
            state_next   = S_LOAD;
          end else begin
            if (sp_eff < PTR_W'(STACK_DEPTH)) begin
              wr_en         = 1'b1;
              sp_next       = sp_eff + PTR_W'(1);
              top_next      = push_val;
              status_r_next = ST_OK;
            end else begin
              // full stack: push dropped
              sp_next       = sp_eff;
              status_r_next = ST_OVER;
            end
            state_next = S_DONE;
          end
        end
      end
      S_LOAD: begin
        alu_req.start = 1'b1;
        state_next    = S_CALC;
      end
      S_CALC: begin
        if (alu_rsp.done) begin
          wr_en         = 1'b1;
          wr_addr       = base_sp[IDX_W-1:0];
          wr_data       = alu_rsp.result;
          sp_next       = base_sp + PTR_W'(1);
          top_next      = alu_rsp.result;
          status_r_next = alu_rsp.fault ? ST_FAULT : (under ? ST_UNDER : ST_OK);
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          res_next.top_value   = (sp == '0) ? '0 : 32'(signed'(top));
          res_next.stack_depth = 5'(sp);
          res_next.status      = status_r;
          res_valid_next       = 1'b1;
          state_next           = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= PTR_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_alu_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_CALC))
    else $error("alu done outside of calc state");

  a_op_leaves_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && alu_rsp.done) |=> (sp != '0))
    else $error("operator left an empty stack");

  a_over_only_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OVER) |-> (res.stack_depth == 5'(STACK_DEPTH)))
    else $error("overflow status with free entries");

  a_start_only_load: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |=> (state == S_CALC))
    else $error("alu start not followed by calc");
`endif

endmodule

// ===== src/pse_stack.sv =====
// pse_stack: operand stack storage, one write port and one registered read port
// depends on pse_pkg for depth and value width
module pse_stack (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [pse_pkg::IDX_W-1:0]      wr_addr,
  input  logic [pse_pkg::VALUE_WIDTH-1:0] wr_data,
  input  logic [pse_pkg::IDX_W-1:0]      rd_addr,
  output logic [pse_pkg::VALUE_WIDTH-1:0] rd_data
);
  import pse_pkg::*;

  logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/pse_alu.sv =====
// pse_alu: shared arithmetic unit; one adder and one multiplier reused for
// add, subtract, multiply, restoring divide and square-and-multiply power
// depends on pse_pkg for operation codes, request and response structs
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  output pse_pkg::alu_rsp_t rsp
);
  import pse_pkg::*;

  localparam int W = VALUE_WIDTH;

  alu_state_t   ast, ast_next;
  logic [W-1:0] acc, acc_next;
  logic [W-1:0] base, base_next;
  logic [W-1:0] ex, ex_next;
  logic [W-1:0] quo, quo_next;
  logic [W-1:0] rem, rem_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic         neg, neg_next;
  logic         done, done_next;
  logic         fault, fault_next;
  logic [W-1:0] result, result_next;

  logic [W-1:0] mul_a, mul_b, prod;
  logic [W:0]   add_a, add_b, sum;
  logic         add_sub;
  logic [W-1:0] left_mag, right_mag;

  assign left_mag  = req.left[W-1]  ? W'(-req.left)  : req.left;
  assign right_mag = req.right[W-1] ? W'(-req.right) : req.right;

  // shared multiplier, low half only
  always_comb begin
    mul_a = req.left;
    mul_b = req.right;
    if (ast == A_PMUL) begin
      mul_a = acc;
      mul_b = base;
    end else if (ast == A_PSQ) begin
      mul_a = base;
      mul_b = base;
    end
    prod = mul_a * mul_b;
  end

  // shared adder
  always_comb begin
    add_a   = {1'b0, req.left};
    add_b   = {1'b0, req.right};
    add_sub = (req.op == OP_SUB);
    if (ast == A_DIV) begin
      add_a   = {rem, quo[W-1]};
      add_b   = {1'b0, base};
      add_sub = 1'b1;
    end else if (ast == A_FIX) begin
      add_a   = '0;
      add_b   = {1'b0, quo};
      add_sub = 1'b1;
    end
    sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ast  <= A_IDLE;
      done <= 1'b0;
    end else begin
      ast  <= ast_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    acc    <= acc_next;
    base   <= base_next;
    ex     <= ex_next;
    quo    <= quo_next;
    rem    <= rem_next;
    cnt    <= cnt_next;
    neg    <= neg_next;
    fault  <= fault_next;
    result <= result_next;
  end

  always_comb begin
    ast_next    = ast;
    acc_next    = acc;
    base_next   = base;
    ex_next     = ex;
    quo_next    = quo;
    rem_next    = rem;
    cnt_next    = cnt;
    neg_next    = neg;
    done_next   = 1'b0;
    fault_next  = fault;
    result_next = result;
    unique case (ast)
      A_IDLE: begin
        if (req.start) begin
          fault_next = 1'b0;
          unique case (req.op) inside
            OP_ADD, OP_SUB: begin
              result_next = sum[W-1:0];
              done_next   = 1'b1;
            end
            OP_MUL: begin
              result_next = prod;
              done_next   = 1'b1;
            end
            OP_DIV: begin
              if (req.right == '0) begin
                result_next = '0;
                fault_next  = 1'b1;
                done_next   = 1'b1;
              end else begin
                quo_next  = left_mag;
                base_next = right_mag;
                rem_next  = '0;
                cnt_next  = '0;
                neg_next  = req.left[W-1] ^ req.right[W-1];
                ast_next  = A_DIV;
              end
            end
            OP_POW: begin
              if (req.right[W-1]) begin
                // negative exponent: only unit magnitudes survive
                done_next = 1'b1;
                if (req.left == W'(1)) begin
                  result_next = W'(1);
                end else if (req.left == '1) begin
                  result_next = req.right[0] ? '1 : W'(1);
                end else begin
                  result_next = '0;
                  fault_next  = (req.left == '0);
                end
              end else if (req.right == '0) begin
                result_next = W'(1);
                done_next   = 1'b1;
              end else begin
                acc_next  = W'(1);
                base_next = req.left;
                ex_next   = req.right;
                ast_next  = A_PMUL;
              end
            end
            default: begin
              result_next = '0;
              done_next   = 1'b1;
            end
          endcase
        end
      end
      A_DIV: begin
        // one quotient bit per cycle
        if (!sum[W]) begin
          rem_next = sum[W-1:0];
        end else begin
          rem_next = {rem[W-2:0], quo[W-1]};
        end
        quo_next = {quo[W-2:0], ~sum[W]};
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          ast_next = A_FIX;
        end
      end
      A_FIX: begin
        result_next = neg ? sum[W-1:0] : quo;
        done_next   = 1'b1;
        ast_next    = A_IDLE;
      end
      A_PMUL: begin
        if (ex[0]) begin
          acc_next = prod;
        end
        ast_next = A_PSQ;
      end
      A_PSQ: begin
        base_next = prod;
        ex_next   = ex >> 1;
        if ((ex >> 1) == '0) begin
          result_next = acc;
          done_next   = 1'b1;
          ast_next    = A_IDLE;
        end else begin
          ast_next = A_PMUL;
        end
      end
      default: ast_next = A_IDLE;
    endcase
  end

  assign rsp.done   = done;
  assign rsp.fault  = fault;
  assign rsp.result = result;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for postfix_stack_evaluator, one request in, one result out
// depends on pse_pkg and the postfix_stack_evaluator rtl; predicts every result in a scoreboard
// class and drives both valid/ready channels with random bursts, gaps and result stalls
module tb_top;
  import pse_pkg::*;

  localparam int REQUEST_TARGET = 1950;
  localparam int IDLE_LIMIT     = 3000;   // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 100;    // room for the longest power request
  localparam int HOLD_OFF       = 400;    // long result stall to back up the request side
  localparam int REPORT_LIMIT   = 10;

  // keeps its own copy of the stack and queues one expected result per accepted request
  class stack_scoreboard;
    logic [31:0] entries[STACK_DEPTH];
    int unsigned depth;
    res_t        expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned deepest;
    int unsigned status_seen[4];

    function new();
      depth      = 0;
      mismatches = 0;
      checked    = 0;
      deepest    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // an empty stack hands out the code of '0' and marks the underflow
    function logic [31:0] pop_operand(inout logic under);
      if (depth == 0) begin
        under = 1'b1;
        return {24'd0, CH_ZERO};
      end
      depth--;
      return entries[depth];
    endfunction

    function logic [31:0] magnitude(logic [31:0] v);
      return v[31] ? -v : v;
    endfunction

    // truncating signed divide; most negative over minus one wraps back to itself
    function logic [31:0] quotient(logic [31:0] lhs, logic [31:0] rhs, output logic fault);
      logic [31:0] q;
      fault = 1'b0;
      if (rhs == 32'd0) begin
        fault = 1'b1;
        return 32'd0;
      end
      q = magnitude(lhs) / magnitude(rhs);
      if (lhs[31] != rhs[31]) q = -q;
      return q;
    endfunction

    // exact power modulo 2^32; negative exponents only survive for bases 1 and -1
    function logic [31:0] power(logic [31:0] base, logic [31:0] ex, output logic fault);
      logic [31:0] acc;
      fault = 1'b0;
      acc   = 32'd1;
      if (ex[31]) begin
        if (base == 32'd1) return 32'd1;
        if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
        fault = (base == 32'd0);
        return 32'd0;
      end
      while (ex != 32'd0) begin
        if (ex[0]) acc = acc * base;
        base = base * base;
        ex   = ex >> 1;
      end
      return acc;
    endfunction

    function void note_request(sym_t req);
      logic [31:0] rhs, lhs, val;
      logic        under, fault;
      res_t        want;
      under       = 1'b0;
      fault       = 1'b0;
      want.status = ST_OK;
      if (req.start_new) depth = 0;
      case (req.symbol) inside
        CH_PLUS, CH_MINUS, CH_TIMES, CH_DIV, CH_POW: begin
          rhs = pop_operand(under);
          lhs = pop_operand(under);
          case (req.symbol)
            CH_PLUS:  val = lhs + rhs;
            CH_MINUS: val = lhs - rhs;
            CH_TIMES: val = lhs * rhs;
            CH_DIV:   val = quotient(lhs, rhs, fault);
            default:  val = power(lhs, rhs, fault);
          endcase
          // two pops always leave room for the push
          entries[depth] = val;
          depth++;
          if (fault) want.status = ST_FAULT;
          else if (under) want.status = ST_UNDER;
        end
        default: begin
          if (depth < STACK_DEPTH) begin
            entries[depth] = {24'd0, req.symbol} - {24'd0, CH_ZERO};
            depth++;
          end else begin
            want.status = ST_OVER;
          end
        end
      endcase
      want.top_value   = (depth > 0) ? entries[depth-1] : 32'd0;
      want.stack_depth = 5'(depth);
      if (depth > deepest) deepest = depth;
      expected_q.push_back(want);
    endfunction

    function void flag(string detail);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch %0d: %s", mismatches, detail);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string detail;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with nothing pending: top %0d depth %0d status %0d",
                       got.top_value, got.stack_depth, got.status));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      status_seen[want.status]++;
      detail = "";
      if (got.top_value !== want.top_value)
        detail = {detail, $sformatf(" top_value exp %0d got %0d", want.top_value,
                                    got.top_value)};
      if (got.stack_depth !== want.stack_depth)
        detail = {detail, $sformatf(" stack_depth exp %0d got %0d", want.stack_depth,
                                    got.stack_depth)};
      if (got.status !== want.status)
        detail = {detail, $sformatf(" status exp %0d got %0d", want.status, got.status)};
      if (detail != "") flag($sformatf("result %0d:%s", checked, detail));
    endfunction
  endclass

  // every input has a known value from time zero
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic sym_valid = 1'b0;
  sym_t sym       = '0;
  logic res_ready = 1'b0;
  logic sym_ready;
  logic res_valid;
  res_t res;

  stack_scoreboard sb = new();

  int unsigned requests_sent = 0;
  int unsigned burst_left    = 0;
  bit          held_off      = 1'b0;

  postfix_stack_evaluator DUT (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels are sampled right at the edge, before any register update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (sym_valid && sym_ready) sb.note_request(sym);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  function automatic bit op_char(logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_TIMES, CH_DIV, CH_POW};
  endfunction

  // mostly digits, some small negatives and wide values, never an operator
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3, 4, 5: c = CH_ZERO + 8'($urandom_range(0, 9));
      6:                c = $urandom_range(0, 1) ? "1" : ".";
      7:                c = $urandom_range(0, 1) ? "," : " ";
      8:                c = 8'($urandom_range(58, 126));
      default:          c = 8'($urandom_range(0, 255));
    endcase
    while (op_char(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // sender: bursts of back-to-back requests separated by short random gaps;
  // valid drops only at the edge that took the last request of a burst
  task automatic offer(logic [7:0] ch, logic fresh);
    if (burst_left == 0) begin
      if (requests_sent != 0) begin
        sym_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    sym       <= '{symbol: ch, start_new: fresh};
    sym_valid <= 1'b1;
    do @(posedge clk); while (!sym_ready);
    burst_left--;
    requests_sent++;
  endtask

  // hand-picked corners: underflow, wraps, faults and odd characters
  task automatic run_directed();
    // operator on an empty stack reads two missing operands
    offer(CH_PLUS, 1'b1);
    // 2^31 gives the most negative value, then divide it by 1 - 2
    offer("2", 1'b1);
    offer("O", 1'b0);
    offer(CH_POW, 1'b0);
    offer("1", 1'b0);
    offer("2", 1'b0);
    offer(CH_MINUS, 1'b0);
    offer(CH_DIV, 1'b0);
    // divide by zero with a missing left operand, fault wins over underflow
    offer("0", 1'b1);
    offer(CH_DIV, 1'b0);
    // zero to a negative power, then zero to the power zero
    offer("0", 1'b1);
    offer(".", 1'b0);
    offer(CH_POW, 1'b0);
    offer("0", 1'b1);
    offer("0", 1'b0);
    offer(CH_POW, 1'b0);
    // minus one to the power minus two
    offer("0", 1'b1);
    offer("1", 1'b0);
    offer(CH_MINUS, 1'b0);
    offer(".", 1'b0);
    offer(CH_POW, 1'b0);
    // lowest and highest character codes, product, then a short subtract
    offer(8'h00, 1'b1);
    offer(8'hFF, 1'b0);
    offer(CH_TIMES, 1'b0);
    offer(CH_MINUS, 1'b0);
  endtask

  // one postfix expression of up to eight operands; the untidy kind keeps the old
  // stack and slips in extra operators that run it dry
  task automatic send_expression(bit tidy);
    int operands;
    int held;
    bit fresh;
    operands = $urandom_range(1, 8);
    held     = 0;
    fresh    = tidy;
    while (operands > 0 || held > 1) begin
      if (!tidy && $urandom_range(0, 4) == 0) begin
        offer(pick_operator(), 1'b0);
      end else if (operands > 0 && (held < 2 || $urandom_range(0, 2) != 0)) begin
        offer(pick_operand(), fresh);
        operands--;
        held++;
      end else begin
        offer(pick_operator(), fresh);
        held--;
      end
      fresh = 1'b0;
    end
  endtask

  // fill the stack past its top so the extra pushes are dropped
  task automatic send_fill();
    offer(pick_operand(), 1'b1);
    repeat (STACK_DEPTH - 1 + $urandom_range(1, 5)) offer(pick_operand(), 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) offer(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // receiver: switches between always ready, coin flip and mostly stalled, and once
  // holds off for a long stretch while the sender keeps offering
  initial begin
    int unsigned mode;
    wait (!rst);
    forever begin
      if (!held_off && requests_sent > 600) begin
        held_off = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 120)) begin
        case (mode)
          0:       res_ready <= 1'b1;
          1:       res_ready <= 1'($urandom_range(0, 1));
          default: res_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog on handshake progress, reset counts as progress
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (sym_valid && sym_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results pending", IDLE_LIMIT,
             sb.expected_q.size());
    $display("postfix_stack_evaluator regression: fail");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (requests_sent < REQUEST_TARGET) begin
      case ($urandom_range(0, 9)) inside
        0, 1, 2, 3, 4, 5, 6: send_expression(1'b1);
        7:                   send_fill();
        8:                   send_noise();
        default:             send_expression(1'b0);
      endcase
    end
    sym_valid <= 1'b0;
    // drain, then leave room for any stray result
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests and %0d results, deepest stack %0d, long stall %0s",
             requests_sent, sb.checked, sb.deepest, held_off ? "done" : "missed");
    $display("status mix: ok %0d, underflow %0d, overflow %0d, fault %0d, mismatches %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_UNDER], sb.status_seen[ST_OVER],
             sb.status_seen[ST_FAULT], sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("postfix_stack_evaluator regression: pass");
    end else begin
      $display("postfix_stack_evaluator regression: fail");
    end
    $finish;
  end

endmodule
